/* hw/rtl/torq_pkg.sv */
// Shared types and constants for the timestamp-ordered request queue.
`timescale 1ns / 1ps

package torq_pkg;

  // Queue geometry
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ID_W  = 8;
  localparam int TIME_W = 15;

  // Request codes as they arrive on in_req_type
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_POP    = 2'd1,
    REQ_DROP   = 2'd2,
    REQ_NONE   = 2'd3
  } req_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Sort key: time in the upper bits, id below, so a plain compare orders both
  typedef struct packed {
    logic [TIME_W-1:0] ts;
    logic [ID_W-1:0]   id;
  } entry_t;

  // Command broadcast to every cell in the chain
  typedef struct packed {
    req_op_t op;
    entry_t  key;
  } cell_cmd_t;

endpackage

/* hw/rtl/torq_cell.sv */
// One slot of the sorted chain: holds an entry and shifts toward either neighbor.
`timescale 1ns / 1ps

module torq_cell (
  input  logic                clk,
  input  torq_pkg::cell_cmd_t cmd,
  input  logic                slot_valid,
  input  logic                lt_left_i,
  input  logic                hit_left_i,
  input  torq_pkg::entry_t    left_entry_i,
  input  torq_pkg::entry_t    right_entry_i,
  output torq_pkg::entry_t    entry_o,
  output logic                lt_o,
  output logic                hit_o
);

  torq_pkg::entry_t entry_r;
  torq_pkg::entry_t entry_nxt;
  logic             match;

  // New key sorts ahead of this entry (ties go behind)
  assign lt_o  = slot_valid && (cmd.key < entry_r);
  // First id match at or left of this cell
  assign match = slot_valid && (entry_r.id == cmd.key.id);
  assign hit_o = hit_left_i || match;

  // Next entry per command
  always_comb begin
    entry_nxt = entry_r;
    unique case (cmd.op)
      torq_pkg::REQ_INSERT: begin
        // left neighbor moves in when insertion point lies left of us;
        // empty slots may take the key freely, they are never read
        if (lt_left_i) begin
          entry_nxt = left_entry_i;
        end else if (lt_o || !slot_valid) begin
          entry_nxt = cmd.key;
        end
      end
      torq_pkg::REQ_POP: begin
        entry_nxt = right_entry_i;
      end
      torq_pkg::REQ_DROP: begin
        if (hit_o) begin
          entry_nxt = right_entry_i;
        end
      end
      torq_pkg::REQ_NONE: begin
        entry_nxt = entry_r;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;

endmodule

/* hw/rtl/timestamp_ordered_request_queue.sv */
// Top level of the timestamp-ordered request queue: cell chain, count and result register.
`timescale 1ns / 1ps

// Sorted queue of up to DEPTH (id, timestamp) entries, ascending by timestamp,
// lower id first on a tie, exact duplicates behind older ones. Each request is
// taken when start is high; busy is always low, so a request can be issued every
// clock. The whole chain of cells updates in the cycle the request is accepted,
// and the single result appears on the out_ ports with out_valid high in the
// next cycle, for that one cycle only: results cannot be stalled and must be
// captured when out_valid is seen. Each request is resolved by the parallel
// compare across the cell chain plus the prefix chain that locates the first
// matching id on a drop.

module timestamp_ordered_request_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_req_type,
  input  logic [torq_pkg::ID_W-1:0]     in_req_id,
  input  logic [torq_pkg::TIME_W-1:0]   in_req_time,
  output logic                          out_valid,
  output logic                          out_head_valid,
  output logic [torq_pkg::ID_W-1:0]     out_head_id,
  output logic [torq_pkg::TIME_W-1:0]   out_head_time,
  output logic [torq_pkg::CNT_W-1:0]    out_entry_count,
  output logic [1:0]                    out_status
);

  localparam int D = torq_pkg::DEPTH;

  logic                        accept;
  torq_pkg::req_op_t           req_op;
  torq_pkg::cell_cmd_t         cmd;
  torq_pkg::status_t           status_nxt;
  torq_pkg::status_t           status_r;
  logic [torq_pkg::CNT_W-1:0]  count_r;
  logic [torq_pkg::CNT_W-1:0]  count_nxt;
  logic                        out_valid_r;
  logic                        is_full;
  logic                        is_empty;
  logic                        found;

  logic             [D-1:0] slot_valid;
  logic             [D-1:0] lt;
  logic             [D-1:0] hit;
  torq_pkg::entry_t [D-1:0] entry;

  // No internal wait states
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign req_op = torq_pkg::req_op_t'(in_req_type);

  assign is_full  = (count_r == torq_pkg::CNT_W'(D));
  assign is_empty = (count_r == '0);
  assign found    = hit[D-1];

  // Occupancy thermometer from the count
  always_comb begin
    for (int k = 0; k < D; k++) begin
      slot_valid[k] = (torq_pkg::CNT_W'(k) < count_r);
    end
  end

  // Command to the chain; rejected requests become holds
  always_comb begin
    cmd.key.ts = in_req_time;
    cmd.key.id = in_req_id;
    cmd.op     = torq_pkg::REQ_NONE;
    if (accept) begin
      unique case (req_op)
        torq_pkg::REQ_INSERT: cmd.op = is_full  ? torq_pkg::REQ_NONE : torq_pkg::REQ_INSERT;
        torq_pkg::REQ_POP:    cmd.op = is_empty ? torq_pkg::REQ_NONE : torq_pkg::REQ_POP;
        torq_pkg::REQ_DROP:   cmd.op = torq_pkg::REQ_DROP;
        torq_pkg::REQ_NONE:   cmd.op = torq_pkg::REQ_NONE;
        default:              cmd.op = torq_pkg::REQ_NONE;
      endcase
    end
  end

  // Status and count update
  always_comb begin
    status_nxt = torq_pkg::ST_OK;
    count_nxt  = count_r;
    unique case (req_op)
      torq_pkg::REQ_INSERT: begin
        if (is_full) begin
          status_nxt = torq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      torq_pkg::REQ_POP: begin
        if (is_empty) begin
          status_nxt = torq_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      torq_pkg::REQ_DROP: begin
        if (found) begin
          count_nxt = count_r - 1'b1;
        end else begin
          status_nxt = torq_pkg::ST_NOTFOUND;
        end
      end
      torq_pkg::REQ_NONE: begin
        status_nxt = torq_pkg::ST_OK;
      end
      default: begin
        status_nxt = torq_pkg::ST_OK;
      end
    endcase
  end

  // Cell chain
  for (genvar k = 0; k < D; k++) begin : g_cell
    torq_pkg::entry_t left_entry;
    torq_pkg::entry_t right_entry;
    logic             lt_left;
    logic             hit_left;

    if (k == 0) begin : g_first
      assign left_entry = cmd.key;
      assign lt_left    = 1'b0;
      assign hit_left   = 1'b0;
    end else begin : g_mid
      assign left_entry = entry[k-1];
      assign lt_left    = lt[k-1];
      assign hit_left   = hit[k-1];
    end

    if (k == D - 1) begin : g_last
      // Slot beyond the end becomes invalid after any left shift
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entry[k+1];
    end

    torq_cell u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .slot_valid   (slot_valid[k]),
      .lt_left_i    (lt_left),
      .hit_left_i   (hit_left),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .entry_o      (entry[k]),
      .lt_o         (lt[k]),
      .hit_o        (hit[k])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= torq_pkg::ST_OK;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r  <= count_nxt;
        status_r <= status_nxt;
      end
    end
  end

  // Result transaction, read from the updated head cell
  assign out_valid       = out_valid_r;
  assign out_head_valid  = !is_empty;
  assign out_head_id     = is_empty ? '0 : entry[0].id;
  assign out_head_time   = is_empty ? '0 : entry[0].ts;
  assign out_entry_count = count_r;
  assign out_status      = status_r;

endmodule
